// ===== hw/rtl/fsdlp_pkg.sv =====
// Shared types and constants of the framed signed decimal list parser.
// Item and result records, character codes and frame state codes.
// No dependencies.
package fsdlp_pkg;

    // default number of value slots
    localparam int DEFAULT_MAX_VALUES = 16;

    // item kinds carried on s_tuser
    localparam logic FUNC_FEED = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // characters of the frame syntax
    localparam logic [7:0] CH_START = 8'h73;  // 's'
    localparam logic [7:0] CH_END   = 8'h65;  // 'e'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // characters allowed in one field
    localparam logic [3:0] FIELD_LIMIT = 4'd15;

    // frame state codes as reported on the result
    localparam logic [1:0] FS_IDLE  = 2'd0;
    localparam logic [1:0] FS_FRAME = 2'd1;
    localparam logic [1:0] FS_DONE  = 2'd2;

    // one input item
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [3:0] read_index;
    } fsdlp_item_t;

    // one result item
    typedef struct packed {
        logic [1:0]         frame_state;
        logic [4:0]         value_count;
        logic               frame_dropped;
        logic               commit_valid;
        logic [3:0]         commit_index;
        logic signed [15:0] commit_value;
        logic signed [15:0] read_value;
    } fsdlp_result_t;

endpackage

// ===== hw/rtl/fsdlp_store.sv =====
// Value store of the parser: one write port, one registered read port.
// A read that meets a write to the same slot returns the new value.
// Depends on nothing but its parameters.
module fsdlp_store #(
    parameter int MAX_VALUES = 16,
    parameter int AW         = 4
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [15:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [15:0] rd_data
);

    logic signed [15:0] mem [MAX_VALUES];
    logic signed [15:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port with write-first bypass
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fsdlp_parser.sv =====
// Frame parser: state registers and the per-item next-state logic.
// Produces the result record and the store write for the item in flight.
// Depends on fsdlp_pkg.
module fsdlp_parser #(
    parameter int MAX_VALUES = 16,
    parameter int AW         = 4,
    parameter int CNT_W      = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   proc_en,
    input  fsdlp_pkg::fsdlp_item_t item,
    input  logic signed [15:0]     rd_data,
    output fsdlp_pkg::fsdlp_result_t result,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic signed [15:0]     wr_data
);
    import fsdlp_pkg::*;

    localparam int CW = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [1:0] {
        ST_IDLE  = FS_IDLE,
        ST_FRAME = FS_FRAME,
        ST_DONE  = FS_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [3:0]         digits_reg, digits_next;
    logic               neg_reg, neg_next;
    logic [15:0]        acc_reg, acc_next;

    logic               dropped;
    logic               commit;
    logic               room;
    logic               is_digit;
    logic [15:0]        field_value;
    logic [15:0]        acc_times_ten;
    logic               read_hit;

    // field value after sign, and the next accumulator step
    assign field_value   = neg_reg ? (16'd0 - acc_reg) : acc_reg;
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);
    assign room          = (slot_reg < CNT_W'(MAX_VALUES));
    assign is_digit      = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
    assign read_hit      = (CW'(item.read_index) < CW'(count_reg))
                        && (CW'(item.read_index) < CW'(MAX_VALUES));

    // next-state logic for one item
    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        dropped     = 1'b0;
        commit      = 1'b0;
        if (item.func == FUNC_FEED) begin
            case (state_reg)
                ST_IDLE, ST_DONE: begin
                    if (item.rx_byte == CH_START) begin
                        state_next  = ST_FRAME;
                        slot_next   = '0;
                        digits_next = '0;
                        neg_next    = 1'b0;
                        acc_next    = '0;
                        if (state_reg == ST_DONE) begin
                            count_next = '0;
                        end
                    end
                end
                ST_FRAME: begin
                    if (item.rx_byte == CH_END) begin
                        if ((digits_reg != 4'd0) && room) begin
                            commit     = 1'b1;
                            count_next = slot_reg + CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end else if (item.rx_byte == CH_COMMA) begin
                        if (digits_reg != 4'd0) begin
                            if (room) begin
                                commit    = 1'b1;
                                slot_next = slot_reg + CNT_W'(1);
                            end
                            digits_next = '0;
                            neg_next    = 1'b0;
                            acc_next    = '0;
                        end
                    end else if (is_digit || (item.rx_byte == CH_MINUS)) begin
                        if (digits_reg >= FIELD_LIMIT) begin
                            state_next = ST_IDLE;
                            dropped    = 1'b1;
                        end else if (item.rx_byte == CH_MINUS) begin
                            if (digits_reg != 4'd0) begin
                                state_next = ST_IDLE;
                                dropped    = 1'b1;
                            end else begin
                                neg_next    = 1'b1;
                                digits_next = digits_reg + 4'd1;
                            end
                        end else begin
                            acc_next    = acc_times_ten + {8'd0, item.rx_byte - CH_ZERO};
                            digits_next = digits_reg + 4'd1;
                        end
                    end else begin
                        state_next = ST_IDLE;
                        dropped    = 1'b1;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            count_reg  <= '0;
            digits_reg <= '0;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
        end else if (proc_en) begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
        end
    end

    // store write
    assign wr_en   = proc_en && commit;
    assign wr_addr = AW'(slot_reg);
    assign wr_data = field_value;

    // result record
    always_comb begin
        result.frame_state   = state_next;
        result.value_count   = 5'(count_next);
        result.frame_dropped = dropped;
        result.commit_valid  = commit;
        result.commit_index  = commit ? 4'(slot_reg) : 4'd0;
        result.commit_value  = commit ? field_value : 16'sd0;
        result.read_value    = ((item.func == FUNC_READ) && read_hit) ? rd_data : 16'sd0;
    end

endmodule

// ===== hw/rtl/framed_signed_decimal_list_parser.sv =====
// Top level of the framed signed decimal list parser: stream ports,
// input and result registers. Depends on fsdlp_pkg, fsdlp_parser, fsdlp_store.
//
// Parses frames such as s12,-34,56e fed one byte per transaction and keeps up
// to MAX_VALUES signed 16-bit values; read transactions return a stored value.
// Each transaction yields exactly one result. The block takes one transaction
// per clock: an input register holds the item while the store's registered
// read for it completes, the parse step runs combinationally between that register
// and the result register, and the sustained rate is one transaction per cycle
// whenever m_tready is high. No clearing pass is needed after reset.
module framed_signed_decimal_list_parser #(
    parameter int MAX_VALUES = fsdlp_pkg::DEFAULT_MAX_VALUES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[11:8], zero[15:12]
    input  logic [0:0]  s_tuser,   // func[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_state[1:0], value_count[6:2], frame_dropped[7], commit_valid[8],
    // commit_index[12:9], commit_value[28:13], read_value[44:29], zero[47:45]
    output logic [47:0] m_tdata
);
    import fsdlp_pkg::*;

    localparam int AW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W = $clog2(MAX_VALUES + 1);

    logic          in_valid_reg;
    fsdlp_item_t   item_reg;
    logic          out_valid_reg;
    fsdlp_result_t result_reg;
    fsdlp_result_t result;
    fsdlp_item_t   s_item;

    logic               advance;
    logic               proc_en;
    logic               s_accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [15:0] wr_data;
    logic signed [15:0] rd_data;

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign s_item.func       = s_tuser[0];
    assign s_item.rx_byte    = s_tdata[7:0];
    assign s_item.read_index = s_tdata[11:8];

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en) begin
            result_reg <= result;
        end
    end

    fsdlp_parser #(
        .MAX_VALUES (MAX_VALUES),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_en),
        .item    (item_reg),
        .rd_data (rd_data),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fsdlp_store #(
        .MAX_VALUES (MAX_VALUES),
        .AW         (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (AW'(s_item.read_index)),
        .rd_data (rd_data)
    );

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0,
                       result_reg.read_value,
                       result_reg.commit_value,
                       result_reg.commit_index,
                       result_reg.commit_valid,
                       result_reg.frame_dropped,
                       result_reg.value_count,
                       result_reg.frame_state};

endmodule

// ===== hw/rtl/fsdlp_checker.sv =====
// Port-level checks of the framed signed decimal list parser, and the bind
// that attaches them to the top level. Depends on fsdlp_pkg.
module fsdlp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import fsdlp_pkg::*;

    logic [1:0]  frame_state;
    logic        frame_dropped;
    logic        commit_valid;
    logic [15:0] read_value;

    assign frame_state   = m_tdata[1:0];
    assign frame_dropped = m_tdata[7];
    assign commit_valid  = m_tdata[8];
    assign read_value    = m_tdata[44:29];

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // an aborted frame always lands in idle
    a_drop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && frame_dropped |-> frame_state == FS_IDLE)
        else $error("dropped frame not idle");

    // a commit never comes with an abort, and only inside or at the end of a frame
    a_commit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && commit_valid |->
            !frame_dropped && (frame_state == FS_FRAME || frame_state == FS_DONE))
        else $error("commit in wrong state");

    // read data only shows on read transactions, which neither commit nor abort
    a_read_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && read_value != 16'd0 |-> !commit_valid && !frame_dropped)
        else $error("read data mixed with parse result");

endmodule

bind framed_signed_decimal_list_parser fsdlp_checker u_fsdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/framed_signed_decimal_list_parser_tb.sv =====
// Self-checking bench for the framed signed decimal list parser: directed and random
// byte and read transactions, each result predicted in step and checked field by field.
// Depends on fsdlp_pkg and framed_signed_decimal_list_parser.
`timescale 1ns / 100ps

module framed_signed_decimal_list_parser_tb;
    import fsdlp_pkg::*;

    localparam int MAX_VALUES  = DEFAULT_MAX_VALUES;
    localparam int HALF_PERIOD = 6;
    localparam int ITEM_TARGET = 450;
    localparam int PHASE_LEN   = 60;
    localparam int DRAIN_A     = 120;
    localparam int DRAIN_B     = 310;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // rx_byte[7:0], read_index[11:8], zero[15:12]
    logic [0:0]  s_tuser  = '0;   // func[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // frame_state[1:0], value_count[6:2], frame_dropped[7], commit_valid[8],
    // commit_index[12:9], commit_value[28:13], read_value[44:29], zero[47:45]
    logic [47:0] m_tdata;

    fsdlp_item_t   frame_items[$];
    fsdlp_result_t due_results[$];
    int            items_total;
    int            items_taken  = 0;
    int            results_seen = 0;
    int            error_count  = 0;
    logic [1:0]    idle_phase   = 2'd0;

    // parser state as seen by the predictor
    logic [1:0]  pr_state = FS_IDLE;
    logic [4:0]  pr_slot  = '0;
    logic [4:0]  pr_count = '0;
    logic [3:0]  pr_chars = '0;
    logic        pr_neg   = 1'b0;
    logic [15:0] pr_acc   = '0;
    logic [15:0] pr_store [MAX_VALUES];

    framed_signed_decimal_list_parser #(
        .MAX_VALUES(MAX_VALUES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // field bookkeeping
    function automatic void clear_field();
        pr_chars = '0;
        pr_neg   = 1'b0;
        pr_acc   = '0;
    endfunction

    function automatic void start_frame();
        pr_state = FS_FRAME;
        pr_slot  = '0;
        clear_field();
    endfunction

    function automatic void commit_field(inout fsdlp_result_t r, input logic [15:0] v);
        pr_store[pr_slot[3:0]] = v;
        r.commit_valid = 1'b1;
        r.commit_index = pr_slot[3:0];
        r.commit_value = v;
    endfunction

    // advance the parser by one transaction and return its result
    function automatic fsdlp_result_t predict_result(input logic func, input logic [7:0] ch,
                                                     input logic [3:0] ridx);
        fsdlp_result_t r;
        logic [15:0]   v;
        r = '0;
        v = pr_neg ? 16'(16'd0 - pr_acc) : pr_acc;
        if (func == FUNC_READ) begin
            if (ridx < pr_count) r.read_value = pr_store[ridx];
        end else begin
            case (pr_state)
                FS_IDLE: begin
                    if (ch == CH_START) start_frame();
                end
                FS_DONE: begin
                    if (ch == CH_START) begin
                        start_frame();
                        pr_count = '0;
                    end
                end
                FS_FRAME: begin
                    if (ch == CH_END) begin
                        if (pr_chars != 0 && pr_slot < MAX_VALUES) begin
                            commit_field(r, v);
                            pr_count = pr_slot + 5'd1;
                        end
                        pr_state = FS_DONE;
                    end else if (ch == CH_COMMA) begin
                        // an empty field changes nothing; a full store drops the value
                        if (pr_chars != 0) begin
                            if (pr_slot < MAX_VALUES) begin
                                commit_field(r, v);
                                pr_slot = pr_slot + 5'd1;
                            end
                            clear_field();
                        end
                    end else if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_MINUS) begin
                        // too long a field or a minus after the first character aborts
                        if (pr_chars >= FIELD_LIMIT || (ch == CH_MINUS && pr_chars != 0)) begin
                            pr_state = FS_IDLE;
                            r.frame_dropped = 1'b1;
                        end else begin
                            if (ch == CH_MINUS)
                                pr_neg = 1'b1;
                            else
                                pr_acc = 16'(pr_acc * 16'd10 + 16'(ch - CH_ZERO));
                            pr_chars = pr_chars + 4'd1;
                        end
                    end else begin
                        pr_state = FS_IDLE;
                        r.frame_dropped = 1'b1;
                    end
                end
                default: begin
                    pr_state = FS_IDLE;
                end
            endcase
        end
        r.frame_state = pr_state;
        r.value_count = pr_count;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // stimulus builders
    task automatic add_byte(input logic [7:0] ch);
        fsdlp_item_t it;
        it.func       = FUNC_FEED;
        it.rx_byte    = ch;
        it.read_index = 4'($urandom_range(0, 15));
        frame_items.push_back(it);
    endtask

    task automatic add_read(input logic [3:0] idx);
        fsdlp_item_t it;
        it.func       = FUNC_READ;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.read_index = idx;
        frame_items.push_back(it);
    endtask

    task automatic add_field(input int len, input bit neg);
        for (int i = 0; i < len; i++) begin
            if (i == 0 && neg)
                add_byte(CH_MINUS);
            else
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // one frame; a broken frame gets one bad spot after a random field
    task automatic add_frame(input int n_fields, input bit short_fields, input bit broken);
        int bad_field;
        int len;
        int pick;
        bad_field = broken ? int'($urandom_range(0, n_fields - 1)) : -1;
        add_byte(CH_START);
        for (int f = 0; f < n_fields; f++) begin
            pick = $urandom_range(0, 99);
            if (short_fields)
                len = $urandom_range(1, 2);
            else if (pick < 80)
                len = $urandom_range(1, 5);
            else if (pick < 88)
                len = $urandom_range(6, 14);
            else if (pick < 94)
                len = FIELD_LIMIT;
            else
                len = 0;
            add_field(len, $urandom_range(0, 3) == 0);
            if (f == bad_field) begin
                case ($urandom_range(0, 2))
                    0: add_byte(8'($urandom_range(0, 255)));
                    1: add_byte(CH_MINUS);
                    default: add_field(FIELD_LIMIT + 1, 1'b0);
                endcase
            end
            if (f != n_fields - 1) add_byte(CH_COMMA);
        end
        add_byte(CH_END);
    endtask

    // sender: presents queued transactions and predicts each accepted one
    always @(posedge aclk) begin : feed_driver
        fsdlp_item_t nxt;
        int          idle_pct;
        bit          holding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(predict_result(s_tuser[0], s_tdata[7:0], s_tdata[11:8]));
                items_taken++;
                idle_phase <= 2'((items_taken / PHASE_LEN) % 4);
            end
            idle_pct = (idle_phase == 2'd1) ? 75 : (idle_phase == 2'd3) ? 14 : 0;
            // at the drain points hold off until every result is back
            holding = (items_taken == DRAIN_A || items_taken == DRAIN_B)
                      && due_results.size() != 0;
            if (!s_tvalid || s_tready) begin
                if (frame_items.size() != 0 && !holding
                    && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = frame_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.func;
                    s_tdata  <= {4'h0, nxt.read_index, nxt.rx_byte};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure and per-field check of each result transaction
    always @(posedge aclk) begin : result_monitor
        fsdlp_result_t want;
        int            stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    want = due_results.pop_front();
                    check_field("frame_state", m_tdata[1:0], want.frame_state);
                    check_field("value_count", m_tdata[6:2], want.value_count);
                    check_field("frame_dropped", m_tdata[7], want.frame_dropped);
                    check_field("commit_valid", m_tdata[8], want.commit_valid);
                    check_field("commit_index", m_tdata[12:9], want.commit_index);
                    check_field("commit_value", $signed(m_tdata[28:13]), want.commit_value);
                    check_field("read_value", $signed(m_tdata[44:29]), want.read_value);
                end
            end
            stall_pct = (idle_phase == 2'd2) ? 75 : (idle_phase == 2'd3) ? 14 : 0;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // stimulus, reset and end of run
    initial begin : run_control
        int pick;

        // directed opening: ignored bytes, minus, empty field, lone minus, reads
        add_read(4'd15);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_END);
        add_byte(CH_START);
        add_byte(CH_MINUS);
        add_byte(CH_NINE);
        add_byte(CH_COMMA);
        add_byte(CH_COMMA);
        add_byte(CH_MINUS);
        add_byte(CH_END);
        add_read(4'd0);
        add_read(4'd1);
        add_read(4'd2);
        // start from done clears the count, then a minus that is not first
        add_byte(CH_START);
        add_byte(CH_ZERO + 8'd5);
        add_byte(CH_MINUS);
        // start from idle, then a foreign byte aborts
        add_byte(CH_START);
        add_byte(CH_NINE);
        add_byte(8'hFF);
        // empty frame ends without a commit
        add_byte(CH_START);
        add_byte(CH_END);
        add_read(4'd0);

        // random part: mostly well-formed frames, some broken ones and noise
        while (frame_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                add_frame($urandom_range(1, 5), 1'b0, 1'b0);
            else if (pick < 66)
                add_frame($urandom_range(14, 18), 1'b1, 1'b0);
            else if (pick < 80)
                add_frame($urandom_range(1, 4), 1'b0, 1'b1);
            else
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) add_read(4'($urandom_range(0, 15)));
        end
        items_total = frame_items.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_taken != items_total || due_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0)
            $display("PASS framed_signed_decimal_list_parser");
        else
            $display("FAIL framed_signed_decimal_list_parser");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL framed_signed_decimal_list_parser");
        $finish;
    end

endmodule
